// File: rtl/hlph_pkg.sv
`timescale 1ns / 1ps

package hlph_pkg;

    // Lattice geometry
    localparam int MAX_SIDE   = 16;
    localparam int SITE_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int SITE_W     = 8;
    localparam int SIDE_W     = 5;

    // Occupancy store organization: one bit per site, packed in words
    localparam int WORD_W     = 16;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = SITE_COUNT / WORD_W;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int NWORD_W    = $clog2(WORD_COUNT + 1);
    localparam int POP_W      = $clog2(WORD_W + 1);

    // Row/column divider step counter
    localparam int STEP_W     = $clog2(SITE_W);

    // Counts and fields
    localparam int CNT_W  = $clog2(SITE_COUNT + 1);
    localparam int RANK_W = 9;
    localparam int DIR_W  = 3;
    localparam int FLUX_W = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(7);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
    localparam logic [FLUX_W-1:0] FLUX_MAX   = {FLUX_W{1'b1}};

    // Operation codes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // Hop directions, east then counterclockwise
    localparam logic [DIR_W-1:0] DIR_E  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NE = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NW = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_SW = 3'd4;
    localparam logic [DIR_W-1:0] DIR_SE = 3'd5;

    // Register map
    localparam logic REG_SIDE = 1'b0;

    // Request bundle into the occupancy memory
    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } occ_req_t;

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] word);
        logic [POP_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < WORD_W; b++) begin
            acc = acc + POP_W'(word[b]);
        end
        return acc;
    endfunction

endpackage

// File: rtl/hlph_occ_mem.sv
`timescale 1ns / 1ps

// Occupancy word store: one write and one read port, registered read.
// Words never written since reset read as all-empty.
module hlph_occ_mem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hlph_pkg::occ_req_t           req,
    output logic [hlph_pkg::WORD_W-1:0]  rd_data
);
    import hlph_pkg::*;

    logic [WORD_W-1:0]     mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]     rd_q_reg;
    logic                  rd_v_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_v_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_v_reg ? rd_q_reg : '0;

endmodule

// File: rtl/hlph_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Splits a site index
// into row (quotient) and column (remainder).
module hlph_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hlph_pkg::SITE_W-1:0] dividend,
    input  logic [hlph_pkg::SIDE_W-1:0] divisor,
    output logic                        done,
    output logic [hlph_pkg::SITE_W-1:0] quotient,
    output logic [hlph_pkg::SIDE_W-1:0] remainder
);
    import hlph_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SITE_W-1:0] quo_reg;
    logic [SIDE_W-1:0] rem_reg;
    logic [SIDE_W-1:0] div_reg;
    logic [SIDE_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SITE_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SITE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SITE_W-2:0], fits};
            rem_reg <= fits ? SIDE_W'(trial - {1'b0, div_reg}) : trial[SIDE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/hex_lattice_particle_hop.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------------------
// in        in_valid / in_ready     operation, site_index, site_value,
//                                   particle_rank, direction
// out       out_valid / out_ready   moved, wrapped, from_site, to_site, flux_count
// cfg       APB psel/penable/pready paddr[2] = register index, pwdata[4:0] = side
//
// Set item: a read-modify-write of one word.
// Move item: a word scan of the occupancy memory (one word per cycle), over at
// most nwords = ceil(side*side/16) words, then the row/column divider.
// One item in flight; a new item is taken as soon as the previous result is
// in the output register, even while that result waits for out_ready.
// Reset is asynchronous and needs no clearing pass: per-word valid bits make
// every word read as empty until first written.
module hex_lattice_particle_hop (
    input  logic                         clk,
    input  logic                         rst_n,
    // input item
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [hlph_pkg::SITE_W-1:0]  site_index,
    input  logic                         site_value,
    input  logic [hlph_pkg::RANK_W-1:0]  particle_rank,
    input  logic [hlph_pkg::DIR_W-1:0]   direction,
    // result item
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         moved,
    output logic                         wrapped,
    output logic [hlph_pkg::SITE_W-1:0]  from_site,
    output logic [hlph_pkg::SITE_W-1:0]  to_site,
    output logic [hlph_pkg::FLUX_W-1:0]  flux_count,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import hlph_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_SET_RD  = 10'b00_0000_0010,
        ST_SET_WR  = 10'b00_0000_0100,
        ST_SCAN    = 10'b00_0000_1000,
        ST_SELECT  = 10'b00_0001_0000,
        ST_DIVIDE  = 10'b00_0010_0000,
        ST_DST_RD  = 10'b00_0100_0000,
        ST_DST_CHK = 10'b00_1000_0000,
        ST_SRC_WR  = 10'b01_0000_0000,
        ST_FINISH  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [SIDE_W-1:0] side_reg;
    logic              cfg_wr;

    // Item fields and per-item geometry
    logic                val_reg;
    logic [SITE_W-1:0]   site_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [DIR_W-1:0]    dir_reg;
    logic [SIDE_W-1:0]   n_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    nn1_reg;
    logic [NWORD_W-1:0]  nwords_reg;

    // Scan state
    logic [NWORD_W-1:0]  issue_w_reg;
    logic [WADDR_W-1:0]  proc_w_reg;
    logic                pend_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WORD_W-1:0]   raw_word_reg;
    logic [WORD_W-1:0]   masked_word_reg;
    logic [POP_W-1:0]    ord_reg;
    logic [SITE_W-1:0]   k_reg;
    logic [SITE_W-1:0]   dst_reg;
    logic                wrap_reg;

    // Working result and flux counter
    logic                res_moved_reg, res_wrapped_reg;
    logic [SITE_W-1:0]   res_from_reg, res_to_reg;
    logic [FLUX_W-1:0]   flux_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_moved_reg, out_wrapped_reg;
    logic [SITE_W-1:0]   out_from_reg, out_to_reg;
    logic [FLUX_W-1:0]   out_flux_reg;

    // Memory and divider
    occ_req_t            mem_req;
    logic [WORD_W-1:0]   rd_data;
    logic                div_start, div_done;
    logic [SITE_W-1:0]   div_quo;
    logic [SIDE_W-1:0]   div_rem;

    logic                in_acc, out_free;

    // ---------------------------------------------------------------
    // Geometry at accept: clamp side, precompute n*n and n*(n-1)
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0]   n_eff;
    logic [2*SIDE_W-1:0] sq_eff;
    logic [2*SIDE_W-1:0] words_sum;

    always_comb
    begin
        if (side_reg < SIDE_MIN)
        begin
            n_eff = SIDE_MIN;
        end
        else if (side_reg > SIDE_MAX)
        begin
            n_eff = SIDE_MAX;
        end
        else
        begin
            n_eff = side_reg;
        end
    end

    assign sq_eff    = n_eff * n_eff;
    assign words_sum = sq_eff + (2*SIDE_W)'(WORD_W - 1);

    // ---------------------------------------------------------------
    // Scan: mask each returned word to the live lattice, count, compare
    // ---------------------------------------------------------------
    logic [WORD_W-1:0] scan_mask, scan_word;
    logic [POP_W-1:0]  scan_pop;
    logic [CNT_W:0]    scan_sum;
    logic              scan_hit, scan_last, scan_issue;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            scan_mask[b] = {1'b0, proc_w_reg, BIT_W'(b)} < total_reg;
        end
    end

    assign scan_word  = rd_data & scan_mask;
    assign scan_pop   = popcount(scan_word);
    assign scan_sum   = {1'b0, cnt_reg} + (CNT_W+1)'(scan_pop);
    assign scan_hit   = pend_reg && (scan_sum >= (CNT_W+1)'(rank_reg));
    assign scan_last  = pend_reg && ({1'b0, proc_w_reg} == nwords_reg - NWORD_W'(1));
    assign scan_issue = !scan_hit && !scan_last && (issue_w_reg < nwords_reg);

    // ---------------------------------------------------------------
    // Select: position of the ord-th set bit in the hit word
    // ---------------------------------------------------------------
    logic [BIT_W-1:0]  sel_bit;
    logic [SITE_W-1:0] sel_site;

    always_comb
    begin
        logic [WORD_W:0] low;
        sel_bit = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            low = ((WORD_W+1)'(2) << b) - (WORD_W+1)'(1);
            if (masked_word_reg[b]
                && popcount(masked_word_reg & low[WORD_W-1:0]) == ord_reg)
            begin
                sel_bit = BIT_W'(b);
            end
        end
    end

    assign sel_site = {proc_w_reg, sel_bit};

    // ---------------------------------------------------------------
    // Neighbour / wrap target from row and column
    // ---------------------------------------------------------------
    logic              at_left, at_right, at_bot, at_top, nb_ok;
    logic [SITE_W-1:0] nb_dst, wrap_dst, tgt_dst;
    logic [SITE_W-1:0] n8, nn18;

    assign n8       = SITE_W'(n_reg);
    assign nn18     = nn1_reg[SITE_W-1:0];
    assign at_left  = div_rem == '0;
    assign at_right = div_rem == n_reg - SIDE_W'(1);
    assign at_bot   = div_quo == '0;
    assign at_top   = div_quo == n8 - SITE_W'(1);

    always_comb
    begin
        case (dir_reg)
            DIR_E:
            begin
                nb_ok  = !at_right;
                nb_dst = k_reg + SITE_W'(1);
            end
            DIR_NE:
            begin
                nb_ok  = !at_right && !at_bot;
                nb_dst = k_reg - n8 + SITE_W'(1);
            end
            DIR_NW:
            begin
                nb_ok  = !at_bot;
                nb_dst = k_reg - n8;
            end
            DIR_W_:
            begin
                nb_ok  = !at_left;
                nb_dst = k_reg - SITE_W'(1);
            end
            DIR_SW:
            begin
                nb_ok  = !at_left && !at_top;
                nb_dst = k_reg + n8 - SITE_W'(1);
            end
            default:
            begin
                nb_ok  = !at_top;
                nb_dst = k_reg + n8;
            end
        endcase

        // Side columns wrap along the row, corners included
        if (at_left)
        begin
            wrap_dst = k_reg + n8 - SITE_W'(1);
        end
        else if (at_right)
        begin
            wrap_dst = k_reg - n8 + SITE_W'(1);
        end
        else if (at_bot)
        begin
            wrap_dst = k_reg + nn18;
        end
        else
        begin
            wrap_dst = k_reg - nn18;
        end

        tgt_dst = nb_ok ? nb_dst : wrap_dst;
    end

    // ---------------------------------------------------------------
    // Memory requests
    // ---------------------------------------------------------------
    logic              dst_busy, same_word;
    logic [WORD_W-1:0] set_word, dst_bit, k_bit;

    assign dst_bit   = WORD_W'(1) << dst_reg[BIT_W-1:0];
    assign k_bit     = WORD_W'(1) << k_reg[BIT_W-1:0];
    assign dst_busy  = rd_data[dst_reg[BIT_W-1:0]];
    assign same_word = dst_reg[SITE_W-1:BIT_W] == k_reg[SITE_W-1:BIT_W];

    always_comb
    begin
        set_word = rd_data;
        set_word[site_reg[BIT_W-1:0]] = val_reg;
    end

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            ST_SET_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = site_reg[SITE_W-1:BIT_W];
            end
            ST_SET_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = site_reg[SITE_W-1:BIT_W];
                mem_req.wr_data = set_word;
            end
            ST_SCAN:
            begin
                mem_req.rd_en   = scan_issue;
                mem_req.rd_addr = issue_w_reg[WADDR_W-1:0];
            end
            ST_DST_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = tgt_dst[SITE_W-1:BIT_W];
            end
            ST_DST_CHK:
            begin
                // same word: place and vacate in one write
                mem_req.wr_en   = !dst_busy;
                mem_req.wr_addr = dst_reg[SITE_W-1:BIT_W];
                mem_req.wr_data = (rd_data | dst_bit) & ~(same_word ? k_bit : '0);
            end
            ST_SRC_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = k_reg[SITE_W-1:BIT_W];
                mem_req.wr_data = raw_word_reg & ~k_bit;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    hlph_occ_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign div_start = (state_reg == ST_SELECT) && (dir_reg <= DIR_SE);

    hlph_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sel_site),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign in_ready = state_reg == ST_IDLE;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (operation == OP_SET)
                    begin
                        state_next = ({1'b0, site_index} < sq_eff[CNT_W-1:0])
                                     ? ST_SET_RD : ST_FINISH;
                    end
                    else
                    begin
                        state_next = (particle_rank == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SET_RD:  state_next = ST_SET_WR;
            ST_SET_WR:  state_next = ST_FINISH;
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_SELECT;
                end
                else if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SELECT:  state_next = div_start ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE:  state_next = div_done ? ST_DST_RD : ST_DIVIDE;
            ST_DST_RD:  state_next = ST_DST_CHK;
            ST_DST_CHK:
            begin
                if (dst_busy || same_word)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SRC_WR;
                end
            end
            ST_SRC_WR:  state_next = ST_FINISH;
            ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    // APB write and readback
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIDE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIDE) ? 32'(side_reg) : 32'd0;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= SIDE_RESET;
            flux_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issue_w_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                side_reg <= pwdata[SIDE_W-1:0];
            end
            if (state_reg == ST_DST_CHK && !dst_busy && wrap_reg && flux_reg != FLUX_MAX)
            begin
                flux_reg <= flux_reg + FLUX_W'(1);
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_acc)
            begin
                pend_reg    <= 1'b0;
                issue_w_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    issue_w_reg <= issue_w_reg + NWORD_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            site_reg        <= site_index;
            val_reg         <= site_value;
            rank_reg        <= particle_rank;
            dir_reg         <= direction;
            n_reg           <= n_eff;
            total_reg       <= sq_eff[CNT_W-1:0];
            nn1_reg         <= sq_eff[CNT_W-1:0] - CNT_W'(n_eff);
            nwords_reg      <= words_sum[BIT_W +: NWORD_W];
            cnt_reg         <= '0;
            res_moved_reg   <= 1'b0;
            res_wrapped_reg <= 1'b0;
            res_from_reg    <= '0;
            res_to_reg      <= '0;
        end

        if (state_reg == ST_SCAN)
        begin
            if (scan_issue)
            begin
                proc_w_reg <= issue_w_reg[WADDR_W-1:0];
            end
            if (scan_hit)
            begin
                raw_word_reg    <= rd_data;
                masked_word_reg <= scan_word;
                ord_reg         <= POP_W'(rank_reg - cnt_reg);
            end
            else if (pend_reg)
            begin
                cnt_reg <= scan_sum[CNT_W-1:0];
            end
        end

        if (state_reg == ST_SELECT)
        begin
            k_reg        <= sel_site;
            res_from_reg <= sel_site;
            res_to_reg   <= sel_site;
        end

        if (state_reg == ST_DST_RD)
        begin
            dst_reg  <= tgt_dst;
            wrap_reg <= !nb_ok;
        end

        if (state_reg == ST_DST_CHK && !dst_busy)
        begin
            res_moved_reg   <= 1'b1;
            res_wrapped_reg <= wrap_reg;
            res_to_reg      <= dst_reg;
        end

        if (state_reg == ST_FINISH && out_free)
        begin
            out_moved_reg   <= res_moved_reg;
            out_wrapped_reg <= res_wrapped_reg;
            out_from_reg    <= res_from_reg;
            out_to_reg      <= res_to_reg;
            out_flux_reg    <= flux_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign moved      = out_moved_reg;
    assign wrapped    = out_wrapped_reg;
    assign from_site  = out_from_reg;
    assign to_site    = out_to_reg;
    assign flux_count = out_flux_reg;

`ifndef SYNTHESIS
    // A move always changes the site
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moved |-> from_site != to_site)
        else $error("moved result with equal sites");

    // A crossing is always a move
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrapped |-> moved)
        else $error("wrapped without move");

    // Nothing moved means the particle stayed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moved |-> to_site == from_site)
        else $error("unmoved result with differing sites");

    // Flux counter never goes down
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> flux_reg >= $past(flux_reg))
        else $error("flux counter decreased");

    // No read of a word in the cycle it is written
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
        else $error("read and write of the same word in one cycle");
`endif

endmodule
